>>> sv/tlg_pkg.sv
// shared types and constants of the toroidal life generation engine
// used by tlg_ctrl, tlg_dpath and the top level; depends on nothing

package tlg_pkg;

  // grid side limit and storage word size
  localparam int GridDim    = 64;
  localparam int WordBits   = 64;
  localparam int DimW       = 7;
  localparam int RowW       = 6;
  localparam int IdxW       = 12;
  localparam int WordAddrW  = 7;

  // command carried by an input item
  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_ADVANCE = 2'd2,
    CMD_NONE    = 2'd3
  } tlg_cmd_e;

  // which row register a fetched row lands in
  typedef enum logic [1:0] {
    DEST_PREV = 2'd0,
    DEST_CUR  = 2'd1,
    DEST_NEXT = 2'd2
  } tlg_dest_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_F_LO,
    S_F_HI,
    S_F_ASM,
    S_PICK,
    S_COMPUTE,
    S_W_LO,
    S_W_HI,
    S_DONE
  } tlg_state_e;

  // controller to datapath
  typedef struct packed {
    logic      ld_item;
    logic      wr_item;
    logic      rd_item;
    logic      frow_last;
    logic      frow_zero;
    logic      frow_next;
    logic      y_clr;
    logic      advance;
    logic      rd_lo;
    logic      rd_hi;
    logic      cap_lo;
    logic      asm_en;
    tlg_dest_e dest;
    logic      next_from_save;
    logic      compute;
    logic      wr_lo;
    logic      wr_hi;
    logic      ld_res;
  } tlg_ctl_t;

  // datapath to controller
  typedef struct packed {
    tlg_cmd_e cmd;
    logic     in_grid;
    logic     last_row;
  } tlg_stat_t;

endpackage

>>> sv/tlg_ctrl.sv
// sequencing state machine of the toroidal life generation engine
// depends on tlg_pkg; drives tlg_dpath through tlg_ctl_t

module tlg_ctrl
  import tlg_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  tlg_stat_t stat_i,
  output tlg_ctl_t  ctl_o
);

  tlg_state_e state_q, state_d;
  tlg_dest_e  dest_q, dest_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dest_q      <= DEST_PREV;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dest_q      <= dest_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    dest_d    = dest_q;
    ctl_o     = '0;
    ctl_o.dest = dest_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctl_o.ld_item = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat_i.cmd)
          CMD_WRITE: begin
            ctl_o.wr_item = stat_i.in_grid;
            state_d       = S_DONE;
          end
          CMD_READ: begin
            ctl_o.rd_item = stat_i.in_grid;
            state_d       = S_DONE;
          end
          CMD_ADVANCE: begin
            ctl_o.frow_last = 1'b1;
            ctl_o.y_clr     = 1'b1;
            dest_d          = DEST_PREV;
            state_d         = S_F_LO;
          end
          CMD_NONE: begin
            state_d = S_DONE;
          end
        endcase
      end
      S_F_LO: begin
        ctl_o.rd_lo = 1'b1;
        state_d     = S_F_HI;
      end
      S_F_HI: begin
        ctl_o.rd_hi  = 1'b1;
        ctl_o.cap_lo = 1'b1;
        state_d      = S_F_ASM;
      end
      S_F_ASM: begin
        ctl_o.asm_en = 1'b1;
        unique case (dest_q)
          DEST_PREV: begin
            ctl_o.frow_zero = 1'b1;
            dest_d          = DEST_CUR;
            state_d         = S_F_LO;
          end
          DEST_CUR:  state_d = S_PICK;
          DEST_NEXT: state_d = S_COMPUTE;
          default:   state_d = S_IDLE;
        endcase
      end
      S_PICK: begin
        // the row below the last one is the saved old row 0
        if (stat_i.last_row) begin
          ctl_o.next_from_save = 1'b1;
          state_d              = S_COMPUTE;
        end else begin
          ctl_o.frow_next = 1'b1;
          dest_d          = DEST_NEXT;
          state_d         = S_F_LO;
        end
      end
      S_COMPUTE: begin
        ctl_o.compute = 1'b1;
        state_d       = S_W_LO;
      end
      S_W_LO: begin
        ctl_o.wr_lo = 1'b1;
        state_d     = S_W_HI;
      end
      S_W_HI: begin
        ctl_o.wr_hi = 1'b1;
        if (stat_i.last_row) begin
          state_d = S_DONE;
        end else begin
          ctl_o.advance = 1'b1;
          state_d       = S_PICK;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          ctl_o.ld_res = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctl_o.ld_res) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_accept_decodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && in_valid_i) |=> (state_q == S_DECODE))
    else $error("accepted item not decoded");

  a_result_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_o.ld_res |-> (!out_valid_q || out_ready_i))
    else $error("result overwrites an undelivered item");

  a_one_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_o.rd_item, ctl_o.rd_lo, ctl_o.rd_hi}))
    else $error("read port driven twice");

  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctl_o.wr_item, ctl_o.wr_lo, ctl_o.wr_hi}))
    else $error("write port driven twice");

endmodule

>>> sv/tlg_dpath.sv
// datapath of the toroidal life generation engine: grid memory, row registers, rule
// depends on tlg_pkg; sequenced by tlg_ctrl

module tlg_dpath
  import tlg_pkg::*;
#(
  parameter int MAX_CELLS = 4096
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tlg_ctl_t         ctl_i,
  output tlg_stat_t        stat_o,
  input  tlg_cmd_e         item_cmd_i,
  input  logic [IdxW-1:0]  item_idx_i,
  input  logic             item_val_i,
  input  logic [DimW-1:0]  wc_i,
  input  logic [DimW-1:0]  hc_i,
  output logic             res_cell_o,
  output logic             res_status_o
);

  localparam int Depth    = (MAX_CELLS < GridDim * GridDim) ? MAX_CELLS : GridDim * GridDim;
  localparam int Words    = (Depth + WordBits - 1) / WordBits;
  localparam int WordAw   = (Words > 1) ? $clog2(Words) : 1;
  localparam int TailBits = Depth - (Words - 1) * WordBits;
  localparam logic [WordBits-1:0] TailMask = {WordBits{1'b1}} >> (WordBits - TailBits);

  // b3/s23 on one row, every column in parallel, wrapping at w
  function automatic logic [WordBits-1:0] life_row(input logic [WordBits-1:0] p,
                                                   input logic [WordBits-1:0] c,
                                                   input logic [WordBits-1:0] n,
                                                   input logic [DimW-1:0]     w);
    logic [WordBits-1:0] res;
    logic [3:0]          cnt;
    logic [RowW-1:0]     li;
    logic [RowW-1:0]     ri;
    res = '0;
    for (int x = 0; x < WordBits; x++) begin
      li = (x == 0) ? RowW'(w - DimW'(1)) : RowW'(x - 1);
      ri = ((x == WordBits - 1) || (DimW'(x + 1) == w)) ? '0 : RowW'(x + 1);
      cnt = 4'(p[li]) + 4'(p[x]) + 4'(p[ri]) + 4'(c[li]) + 4'(c[ri])
          + 4'(n[li]) + 4'(n[x]) + 4'(n[ri]);
      res[x] = (cnt == 4'd3) || (c[x] && (cnt == 4'd2));
    end
    return res;
  endfunction

  // item latch
  tlg_cmd_e        cmd_q;
  logic [IdxW-1:0] idx_q;
  logic            val_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_item) begin
      cmd_q <= item_cmd_i;
      idx_q <= item_idx_i;
      val_q <= item_val_i;
    end
  end

  // cells in use
  logic [2*DimW-1:0] cells;
  logic [2*DimW-1:0] used;
  logic              in_grid;

  assign cells   = (2*DimW)'(wc_i) * (2*DimW)'(hc_i);
  assign used    = (cells > (2*DimW)'(Depth)) ? (2*DimW)'(Depth) : cells;
  assign in_grid = ((2*DimW)'(idx_q) < used);

  // row counters
  logic [RowW-1:0] y_q;
  logic [RowW-1:0] frow_q;
  logic            last_row;

  assign last_row = ((DimW'(y_q) + DimW'(1)) == hc_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_q    <= '0;
      frow_q <= '0;
    end else begin
      if (ctl_i.y_clr) begin
        y_q <= '0;
      end else if (ctl_i.advance) begin
        y_q <= y_q + RowW'(1);
      end
      priority if (ctl_i.frow_last) begin
        frow_q <= RowW'(hc_i - DimW'(1));
      end else if (ctl_i.frow_zero) begin
        frow_q <= '0;
      end else if (ctl_i.frow_next) begin
        frow_q <= y_q + RowW'(1);
      end
    end
  end

  assign stat_o.cmd      = cmd_q;
  assign stat_o.in_grid  = in_grid;
  assign stat_o.last_row = last_row;

  // row start offsets in the row-major bit store
  logic [IdxW:0]       fs_full;
  logic [IdxW:0]       sy_full;
  logic [IdxW-1:0]     fs;
  logic [IdxW-1:0]     sy;
  logic [WordBits-1:0] wmask;

  assign fs_full = (IdxW+1)'(frow_q) * (IdxW+1)'(wc_i);
  assign sy_full = (IdxW+1)'(y_q) * (IdxW+1)'(wc_i);
  assign fs      = fs_full[IdxW-1:0];
  assign sy      = sy_full[IdxW-1:0];
  assign wmask   = {WordBits{1'b1}} >> (WordBits - int'(wc_i));

  // grid memory, 64-bit words with bit enables; unwritten words read as dead
  logic [WordBits-1:0]  mem_q [Words];
  logic [Words-1:0]     word_vld_q;
  logic [WordBits-1:0]  rd_raw_q;
  logic                 rd_ok_q;
  logic [WordBits-1:0]  rd_word;
  logic                 rd_en;
  logic [WordAddrW-1:0] ra;
  logic [WordAw-1:0]    ri;
  logic                 ra_ok;

  assign rd_en = ctl_i.rd_item | ctl_i.rd_lo | ctl_i.rd_hi;

  always_comb begin
    priority if (ctl_i.rd_item) begin
      ra = WordAddrW'(idx_q[IdxW-1:RowW]);
    end else if (ctl_i.rd_lo) begin
      ra = WordAddrW'(fs[IdxW-1:RowW]);
    end else begin
      ra = WordAddrW'(fs[IdxW-1:RowW]) + WordAddrW'(1);
    end
  end

  assign ri    = ra[WordAw-1:0];
  assign ra_ok = (ra < WordAddrW'(Words));

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_raw_q <= mem_q[ri];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ok_q <= 1'b0;
    end else if (rd_en) begin
      rd_ok_q <= ra_ok && word_vld_q[ri];
    end
  end

  assign rd_word = rd_ok_q ? rd_raw_q : '0;

  // row registers
  logic [WordBits-1:0]   lo_q;
  logic [WordBits-1:0]   prev_q;
  logic [WordBits-1:0]   cur_q;
  logic [WordBits-1:0]   next_q;
  logic [WordBits-1:0]   save0_q;
  logic [WordBits-1:0]   new_q;
  logic [2*WordBits-1:0] pair_sh;
  logic [WordBits-1:0]   fetched;

  assign pair_sh = {rd_word, lo_q} >> fs[RowW-1:0];
  assign fetched = pair_sh[WordBits-1:0] & wmask;

  always_ff @(posedge clk_i) begin
    if (ctl_i.cap_lo) begin
      lo_q <= rd_word;
    end
    if (ctl_i.compute) begin
      new_q <= life_row(prev_q, cur_q, next_q, wc_i);
    end
    priority if (ctl_i.advance) begin
      prev_q <= cur_q;
      cur_q  <= next_q;
    end else if (ctl_i.next_from_save) begin
      next_q <= save0_q;
    end else if (ctl_i.asm_en) begin
      unique case (ctl_i.dest)
        DEST_PREV: prev_q <= fetched;
        DEST_CUR: begin
          cur_q   <= fetched;
          save0_q <= fetched;
        end
        DEST_NEXT: next_q <= fetched;
        default: ;
      endcase
    end
  end

  // write port
  logic [2*WordBits-1:0] wdat_sh;
  logic [2*WordBits-1:0] wmsk_sh;
  logic                  wr_en;
  logic [WordAddrW-1:0]  wa;
  logic [WordAw-1:0]     wi;
  logic                  wa_ok;
  logic [WordBits-1:0]   wr_data;
  logic [WordBits-1:0]   wr_mask;
  logic [WordBits-1:0]   wr_bits;

  assign wdat_sh = {{WordBits{1'b0}}, new_q & wmask} << sy[RowW-1:0];
  assign wmsk_sh = {{WordBits{1'b0}}, wmask} << sy[RowW-1:0];
  assign wr_en   = ctl_i.wr_item | ctl_i.wr_lo | ctl_i.wr_hi;

  always_comb begin
    priority if (ctl_i.wr_item) begin
      wa      = WordAddrW'(idx_q[IdxW-1:RowW]);
      wr_data = WordBits'(val_q) << idx_q[RowW-1:0];
      wr_mask = WordBits'(1) << idx_q[RowW-1:0];
    end else if (ctl_i.wr_lo) begin
      wa      = WordAddrW'(sy[IdxW-1:RowW]);
      wr_data = wdat_sh[WordBits-1:0];
      wr_mask = wmsk_sh[WordBits-1:0];
    end else begin
      wa      = WordAddrW'(sy[IdxW-1:RowW]) + WordAddrW'(1);
      wr_data = wdat_sh[2*WordBits-1:WordBits];
      wr_mask = wmsk_sh[2*WordBits-1:WordBits];
    end
  end

  assign wi    = wa[WordAw-1:0];
  assign wa_ok = (wa < WordAddrW'(Words));

  // cells past storage never take a write; a first write fills the word
  always_comb begin
    logic [WordBits-1:0] m;
    m       = (wa == WordAddrW'(Words - 1)) ? (wr_mask & TailMask) : wr_mask;
    wr_bits = word_vld_q[wi] ? m : {WordBits{1'b1}};
  end

  always_ff @(posedge clk_i) begin
    if (wr_en && wa_ok) begin
      for (int b = 0; b < WordBits; b++) begin
        if (wr_bits[b]) begin
          mem_q[wi][b] <= wr_data[b] & wr_mask[b] &
                          ((wa == WordAddrW'(Words - 1)) ? TailMask[b] : 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_vld_q <= '0;
    end else if (wr_en && wa_ok) begin
      word_vld_q[wi] <= 1'b1;
    end
  end

  // result register payload
  logic res_cell_q;
  logic res_status_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_res) begin
      res_status_q <= ((cmd_q == CMD_WRITE) || (cmd_q == CMD_READ)) && !in_grid;
      res_cell_q   <= (cmd_q == CMD_READ) && in_grid && rd_word[idx_q[RowW-1:0]];
    end
  end

  assign res_cell_o   = res_cell_q;
  assign res_status_o = res_status_q;

endmodule

>>> sv/toroidal_life_generation_engine_unit.sv
// toroidal b3/s23 life engine: grid store, one-cell write/read, whole-generation advance
// write, read and unused command pass the decode and done states before the result register
// advance: each row takes a 2-word fetch, pick,
// compute and a 2-word write, the last row reuses the saved old row 0
// one item at a time; a new item is taken while the previous result waits
// reset: grid reads all dead through per-word valid flags, no clearing pass; sizes 64

module toroidal_life_generation_engine_unit
  import tlg_pkg::*;
#(
  parameter int MAX_CELLS = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // cell_index[11:0], cell_in[12], zero[15:13]
  input  logic [1:0]  s_axis_tuser_i,   // cmd[1:0]
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // cell_out[0], status[1], zero[7:2]
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // size registers, raw as written
  logic [DimW-1:0] grid_width_q;
  logic [DimW-1:0] grid_height_q;
  logic            cfg_wr;

  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= DimW'(GridDim);
      grid_height_q <= DimW'(GridDim);
    end else if (cfg_wr) begin
      // word address picks the register, byte lanes ignored
      if (paddr[2]) begin
        grid_height_q <= pwdata[DimW-1:0];
      end else begin
        grid_width_q <= pwdata[DimW-1:0];
      end
    end
  end

  assign prdata = paddr[2] ? 32'(grid_height_q) : 32'(grid_width_q);

  // zero acts as one, anything past the maximum acts as the maximum
  function automatic logic [DimW-1:0] clamp_dim(input logic [DimW-1:0] v);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (v > DimW'(GridDim)) begin
      r = DimW'(GridDim);
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [DimW-1:0] wc;
  logic [DimW-1:0] hc;

  assign wc = clamp_dim(grid_width_q);
  assign hc = clamp_dim(grid_height_q);

  tlg_ctl_t  ctl;
  tlg_stat_t stat;
  logic      res_cell;
  logic      res_status;

  tlg_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (stat),
    .ctl_o       (ctl)
  );

  tlg_dpath #(
    .MAX_CELLS (MAX_CELLS)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .stat_o       (stat),
    .item_cmd_i   (tlg_cmd_e'(s_axis_tuser_i)),
    .item_idx_i   (s_axis_tdata_i[IdxW-1:0]),
    .item_val_i   (s_axis_tdata_i[IdxW]),
    .wc_i         (wc),
    .hc_i         (hc),
    .res_cell_o   (res_cell),
    .res_status_o (res_status)
  );

  assign m_axis_tdata_o = {6'b0, res_status, res_cell};

endmodule
